[rtl/core/pacp_pkg.sv]
// ----------------------------------------------------------------------------
// pacp_pkg
// Shared constants for the pixel alpha composite and pack unit.
// ----------------------------------------------------------------------------
package pacp_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;

  // APB register map, byte address = 4 * index
  localparam int unsigned APB_ADDR_W = 5;
  localparam logic [2:0]  REG_CHANNEL_MAX      = 3'd0;
  localparam logic [2:0]  REG_CHANNEL_SHIFT    = 3'd1;
  localparam logic [2:0]  REG_BYTES_PER_PIXEL  = 3'd2;
  localparam logic [2:0]  REG_MSB_FIRST        = 3'd3;
  localparam logic [2:0]  REG_SOLID_BACKGROUND = 3'd4;
  localparam logic [2:0]  REG_SOLID_COLOR      = 3'd5;
  localparam logic [2:0]  REG_SOURCE_HAS_ALPHA = 3'd6;

  // reset values
  localparam logic [23:0] CHANNEL_MAX_RST   = 24'hFFFFFF;
  localparam logic [14:0] CHANNEL_SHIFT_RST = 15'd272;
  localparam logic [2:0]  BPP_RST           = 3'd4;

  // arithmetic constants
  localparam logic [7:0]  GREY_DARK   = 8'd120;
  localparam logic [7:0]  GREY_LIGHT  = 8'd200;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0] ROUND_255   = 16'd127;
  // floor(v/255) = (v * DIV255_MUL) >> 23, exact for any 16-bit v
  localparam logic [15:0] DIV255_MUL  = 16'd32897;

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'(DIV255_MUL);
    return p[30:23];
  endfunction

endpackage

[rtl/core/pixel_alpha_composite_pack_unit.sv]
// ----------------------------------------------------------------------------
// pixel_alpha_composite_pack_unit
// Composites a source or background pixel, scales and packs the RGB channels
// into one pixel word and emits it as 1 to 4 bytes in memory order.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  in       | in_valid_i / in_stall_o   | req_type, pixel_x/y, src_rgba
//  out      | out_valid_o / out_stall_i | pixel_bytes, byte_count
//  apb      | psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
//  One item per clock sustained while out_stall_i stays low; five register
//  stages, and out_valid_o is the valid bit of the fifth. The two
//  multiply-by-reciprocal divides by 255 set the stage count: each product
//  is registered before the next use.
//  Reset clears the stage valid bits and loads the register defaults.
//  Each stage holds while its successor is full and stalled, so bubbles
//  are squeezed out and the input keeps flowing while a result waits.
// ----------------------------------------------------------------------------
module pixel_alpha_composite_pack_unit
  import pacp_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [7:0]            src_red_i,
  input  logic [7:0]            src_green_i,
  input  logic [7:0]            src_blue_i,
  input  logic [7:0]            src_alpha_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           pixel_bytes_o,
  output logic [2:0]            byte_count_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] chan_max_q;
  logic [14:0] chan_shift_q;
  logic [2:0]  bpp_q;
  logic        msb_first_q;
  logic        solid_bg_q;
  logic [23:0] solid_color_q;
  logic        has_alpha_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_max_q    <= CHANNEL_MAX_RST;
      chan_shift_q  <= CHANNEL_SHIFT_RST;
      bpp_q         <= BPP_RST;
      msb_first_q   <= 1'b0;
      solid_bg_q    <= 1'b0;
      solid_color_q <= '0;
      has_alpha_q   <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CHANNEL_MAX:      chan_max_q    <= pwdata[23:0];
        REG_CHANNEL_SHIFT:    chan_shift_q  <= pwdata[14:0];
        REG_BYTES_PER_PIXEL:  bpp_q         <= pwdata[2:0];
        REG_MSB_FIRST:        msb_first_q   <= pwdata[0];
        REG_SOLID_BACKGROUND: solid_bg_q    <= pwdata[0];
        REG_SOLID_COLOR:      solid_color_q <= pwdata[23:0];
        REG_SOURCE_HAS_ALPHA: has_alpha_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CHANNEL_MAX:      prdata = {8'd0, chan_max_q};
      REG_CHANNEL_SHIFT:    prdata = {17'd0, chan_shift_q};
      REG_BYTES_PER_PIXEL:  prdata = {29'd0, bpp_q};
      REG_MSB_FIRST:        prdata = {31'd0, msb_first_q};
      REG_SOLID_BACKGROUND: prdata = {31'd0, solid_bg_q};
      REG_SOLID_COLOR:      prdata = {8'd0, solid_color_q};
      REG_SOURCE_HAS_ALPHA: prdata = {31'd0, has_alpha_q};
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage flow control: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: background, color select, blend numerator
  // --------------------------------------------------------------------------
  logic [2:0][7:0]  src;
  logic [2:0][7:0]  bg;
  logic [7:0]       grey;
  logic [7:0]       inv_alpha;
  logic             do_blend;
  logic [2:0][15:0] num1_d;
  logic [2:0][15:0] num1_q;
  logic             blend1_q;

  assign src       = {src_blue_i, src_green_i, src_red_i};
  // checker square parity is bit 4 of x plus bit 4 of y
  assign grey      = (pixel_x_i[4] ^ pixel_y_i[4]) ? GREY_DARK : GREY_LIGHT;
  assign inv_alpha = ALPHA_OPAQUE - src_alpha_i;
  assign do_blend  = req_type_i && has_alpha_q && (src_alpha_i != ALPHA_OPAQUE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bg[k] = solid_bg_q ? solid_color_q[8*k +: 8] : grey;
      if (do_blend) begin
        num1_d[k] = 16'(16'(src[k]) * 16'(src_alpha_i))
                  + 16'(16'(bg[k]) * 16'(inv_alpha)) + ROUND_255;
      end else if (req_type_i) begin
        num1_d[k] = {8'd0, src[k]};
      end else begin
        num1_d[k] = {8'd0, bg[k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      num1_q   <= num1_d;
      blend1_q <= do_blend;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: blend divide by 255
  // --------------------------------------------------------------------------
  logic [2:0][7:0] col2_d;
  logic [2:0][7:0] col2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      col2_d[k] = blend1_q ? div255(num1_q[k]) : num1_q[k][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) col2_q <= col2_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: scale numerator c*max + 127
  // --------------------------------------------------------------------------
  logic [2:0][15:0] num3_d;
  logic [2:0][15:0] num3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num3_d[k] = 16'(16'(col2_q[k]) * 16'(chan_max_q[8*k +: 8])) + ROUND_255;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) num3_q <= num3_d;
  end

  // --------------------------------------------------------------------------
  // Stage 4: scale divide by 255
  // --------------------------------------------------------------------------
  logic [2:0][7:0] lvl4_d;
  logic [2:0][7:0] lvl4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lvl4_d[k] = div255(num3_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) lvl4_q <= lvl4_d;
  end

  // --------------------------------------------------------------------------
  // Stage 5: shift, mask, merge, byte order
  // --------------------------------------------------------------------------
  logic [31:0] word;
  logic [2:0]  nbytes;
  logic [1:0]  bsel;
  logic [31:0] bytes5_d;
  logic [31:0] bytes5_q;
  logic [2:0]  cnt5_q;

  always_comb begin
    word = '0;
    for (int k = 0; k < 3; k++) begin
      // (v << sh) & (max << sh) == (v & max) << sh, cut to 32 bits
      word = word | 32'({32'd0, (lvl4_q[k] & chan_max_q[8*k +: 8])}
                        << chan_shift_q[5*k +: 5]);
    end
  end

  assign nbytes = (bpp_q >= 3'd2 && bpp_q <= 3'd4) ? bpp_q : 3'd1;

  always_comb begin
    bytes5_d = '0;
    bsel     = '0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < nbytes) begin
        bsel = msb_first_q ? 2'(nbytes - 3'(i) - 3'd1) : 2'(i);
        bytes5_d[8*i +: 8] = word[8*bsel +: 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      bytes5_q <= bytes5_d;
      cnt5_q   <= nbytes;
    end
  end

  assign out_valid_o   = v5_q;
  assign pixel_bytes_o = bytes5_q;
  assign byte_count_o  = cnt5_q;

endmodule

[rtl/core/pacp_checker.sv]
// ----------------------------------------------------------------------------
// pacp_checker
// Port-level checks for the pixel alpha composite and pack unit.
// ----------------------------------------------------------------------------
module pacp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pixel_bytes_o,
  input logic [2:0]  byte_count_o,
  input logic        pready
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(pixel_bytes_o) && $stable(byte_count_o))
    else $error("stalled result item changed");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o >= 3'd1 && byte_count_o <= 3'd4)
    else $error("byte_count out of range");

  a_single_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == 3'd1 |-> pixel_bytes_o[31:8] == 24'd0)
    else $error("bytes above byte_count not zero");

  // empty output stage means the pipe can always take an item
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind pixel_alpha_composite_pack_unit pacp_checker u_pacp_checker (.*);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pixel_alpha_composite_pack_unit. Pixels go in over
// the valid/stall channel, and every accepted pixel gets its packed bytes
// predicted from a shadow copy of the APB registers. Results are matched in
// order against that prediction. Covers directed corner pixels, register
// sweeps, APB readback, random traffic over many register settings, and a
// long output hold that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top
  import pacp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W      = COORD_BITS_DEF;
  localparam int CLK_HALF     = 6;        // 12 ns clock
  localparam int RST_CYCLES   = 5;
  localparam int PIPE_LATENCY = 4;        // accept to out_valid_o
  localparam int IDLE_PCT     = 31;       // idle/stall chance per cycle
  localparam int HOLD_CYCLES  = 80;       // long receiver hold-off
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 100;      // 12 x 100 random pixels
  localparam int CALM_PHASE   = 5;        // phase with no idling at all
  localparam int CYCLE_LIMIT  = 100000;
  localparam int MAX_REPORTS  = 10;

  // request kinds on req_type_i
  localparam logic REQ_BACKGROUND = 1'b0;
  localparam logic REQ_SOURCE     = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } pixel_req_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
  } packed_pixel_t;

  // shadow of the register file
  typedef struct {
    logic [23:0] chan_max;
    logic [14:0] chan_shift;
    logic [2:0]  bpp;
    logic        msb_first;
    logic        solid_bg;
    logic [23:0] solid_color;
    logic        alpha_en;
  } unit_cfg_t;

  logic               clk;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [7:0]         src_red;
  logic [7:0]         src_green;
  logic [7:0]         src_blue;
  logic [7:0]         src_alpha;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        pixel_bytes;
  logic [2:0]         byte_count;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  unit_cfg_t     cfg;
  packed_pixel_t expected_pixels[$];
  int            failures;
  int            cycles;
  bit            calm;          // no idling on either side while set
  bit            hold_request;  // asks the receiver for a long hold-off

  pixel_alpha_composite_pack_unit #(
    .COORD_BITS(COORD_W)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .pixel_x_i    (pixel_x),
    .pixel_y_i    (pixel_y),
    .src_red_i    (src_red),
    .src_green_i  (src_green),
    .src_blue_i   (src_blue),
    .src_alpha_i  (src_alpha),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_bytes_o(pixel_bytes),
    .byte_count_o (byte_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: composite, scale, pack and byte-order one pixel.
  // --------------------------------------------------------------------------
  function automatic packed_pixel_t composite_pixel(pixel_req_t p, unit_cfg_t c);
    int unsigned   src[3];
    int unsigned   bg[3];
    int unsigned   col[3];
    int unsigned   grey;
    int unsigned   alpha;
    int unsigned   mx;
    int unsigned   sh;
    int unsigned   v;
    int unsigned   n;
    int unsigned   idx;
    int unsigned   square;
    logic [63:0]   wide_val;
    logic [63:0]   wide_msk;
    logic [31:0]   word;
    packed_pixel_t r;
    src[0] = p.red;
    src[1] = p.green;
    src[2] = p.blue;
    alpha  = p.alpha;
    // checkerboard of 16x16 squares, dark when the square index sum is odd
    square = int'(p.x >> 4) + int'(p.y >> 4);
    grey   = square[0] ? GREY_DARK : GREY_LIGHT;
    for (int k = 0; k < 3; k++)
      bg[k] = c.solid_bg ? int'(c.solid_color[8*k +: 8]) : grey;

    if (p.req_type == REQ_BACKGROUND) begin
      col = bg;
    end else if (!c.alpha_en || alpha == ALPHA_OPAQUE) begin
      col = src;
    end else begin
      for (int k = 0; k < 3; k++)
        col[k] = (src[k] * alpha + bg[k] * (255 - alpha) + ROUND_255) / 255;
    end

    // scale to the channel maximum, shift, and keep only the masked bits
    word = '0;
    for (int k = 0; k < 3; k++) begin
      mx       = c.chan_max[8*k +: 8];
      sh       = c.chan_shift[5*k +: 5];
      v        = (col[k] * mx + ROUND_255) / 255;
      wide_val = 64'(v) << sh;
      wide_msk = 64'(mx) << sh;
      word    |= wide_val[31:0] & wide_msk[31:0];
    end

    n       = (c.bpp >= 3'd2 && c.bpp <= 3'd4) ? int'(c.bpp) : 1;
    r.bytes = '0;
    r.count = 3'(n);
    for (int unsigned i = 0; i < n; i++) begin
      idx = (c.msb_first && n > 1) ? n - 1 - i : i;
      r.bytes[8*i +: 8] = word[8*idx +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] cfg_value(logic [2:0] idx);
    case (idx)
      REG_CHANNEL_MAX:      return 32'(cfg.chan_max);
      REG_CHANNEL_SHIFT:    return 32'(cfg.chan_shift);
      REG_BYTES_PER_PIXEL:  return 32'(cfg.bpp);
      REG_MSB_FIRST:        return 32'(cfg.msb_first);
      REG_SOLID_BACKGROUND: return 32'(cfg.solid_bg);
      REG_SOLID_COLOR:      return 32'(cfg.solid_color);
      REG_SOURCE_HAS_ALPHA: return 32'(cfg.alpha_en);
      default:              return '0;
    endcase
  endfunction

  function automatic pixel_req_t make_pixel(logic kind, int x, int y,
                                            int r, int g, int b, int a);
    pixel_req_t p;
    p.req_type = kind;
    p.x        = COORD_W'(x);
    p.y        = COORD_W'(y);
    p.red      = 8'(r);
    p.green    = 8'(g);
    p.blue     = 8'(b);
    p.alpha    = 8'(a);
    return p;
  endfunction

  // random pixel, alpha biased toward transparent, opaque and near-opaque
  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    p.req_type = ($urandom_range(0, 3) == 0) ? REQ_BACKGROUND : REQ_SOURCE;
    p.x        = COORD_W'($urandom);
    p.y        = COORD_W'($urandom);
    p.red      = 8'($urandom);
    p.green    = 8'($urandom);
    p.blue     = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       p.alpha = 8'd0;
      1:       p.alpha = ALPHA_OPAQUE;
      2:       p.alpha = 8'd254;
      default: p.alpha = 8'($urandom);
    endcase
    return p;
  endfunction

  task automatic report_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // APB: setup cycle, then access cycle held until pready.
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic [2:0] idx, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    apb_access(idx, 1'b1, val, unused);
    case (idx)
      REG_CHANNEL_MAX:      cfg.chan_max    = val[23:0];
      REG_CHANNEL_SHIFT:    cfg.chan_shift  = val[14:0];
      REG_BYTES_PER_PIXEL:  cfg.bpp         = val[2:0];
      REG_MSB_FIRST:        cfg.msb_first   = val[0];
      REG_SOLID_BACKGROUND: cfg.solid_bg    = val[0];
      REG_SOLID_COLOR:      cfg.solid_color = val[23:0];
      REG_SOURCE_HAS_ALPHA: cfg.alpha_en    = val[0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input side: random idle cycles before each item, then hold until taken.
  // The prediction is made at the accepting edge, against the live shadow.
  // --------------------------------------------------------------------------
  task automatic send_pixel(input pixel_req_t p);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= p.req_type;
    pixel_x   <= p.x;
    pixel_y   <= p.y;
    src_red   <= p.red;
    src_green <= p.green;
    src_blue  <= p.blue;
    src_alpha <= p.alpha;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(composite_pixel(p, cfg));
  endtask

  // drop valid, let every result drain, then give the pipe time to empty
  task automatic settle_unit();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, or a long hold-off when one is requested.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // each accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    packed_pixel_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_failure($sformatf("result with nothing expected: bytes %h count %0d",
                                 pixel_bytes, byte_count));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_bytes !== want.bytes || byte_count !== want.count)
          report_failure($sformatf("pixel_bytes exp %h got %h, byte_count exp %0d got %0d",
                                   want.bytes, pixel_bytes, want.count, byte_count));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset register values: checkerboard, alpha on, 4 bytes LSB first
  task automatic test_reset_state();
    // checkerboard squares and coordinate extremes; source fields ignored
    send_pixel(make_pixel(REQ_BACKGROUND, 0, 0, 255, 255, 255, 255));
    send_pixel(make_pixel(REQ_BACKGROUND, 16, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(REQ_BACKGROUND, 15, 16, 17, 34, 51, 68));
    send_pixel(make_pixel(REQ_BACKGROUND, 4095, 4095, 0, 0, 0, 0));
    send_pixel(make_pixel(REQ_BACKGROUND, 4080, 15, 0, 0, 0, 0));
    // opaque source goes straight through
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 255, 0, 128, 255));
    // fully transparent and half alpha over both greys
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 200, 10, 255, 0));
    send_pixel(make_pixel(REQ_SOURCE, 16, 0, 255, 255, 255, 128));
    send_pixel(make_pixel(REQ_SOURCE, 4095, 4095, 0, 0, 0, 1));
  endtask

  // byte order, odd byte counts, masks, large shifts, solid background
  task automatic test_register_settings();
    settle_unit();
    write_reg(REG_BYTES_PER_PIXEL, 32'd2);
    write_reg(REG_MSB_FIRST, 32'd1);
    send_pixel(make_pixel(REQ_SOURCE, 3, 3, 18, 52, 86, 255));
    send_pixel(make_pixel(REQ_BACKGROUND, 3, 20, 0, 0, 0, 0));

    // out-of-range byte counts store the low byte only, msb_first ignored
    settle_unit();
    write_reg(REG_BYTES_PER_PIXEL, 32'd0);
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 18, 52, 86, 255));
    settle_unit();
    write_reg(REG_BYTES_PER_PIXEL, 32'd7);
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 86, 52, 18, 255));

    // 565-style word, three bytes MSB first
    settle_unit();
    write_reg(REG_BYTES_PER_PIXEL, 32'd3);
    write_reg(REG_CHANNEL_MAX, 32'h1F3F1F);
    write_reg(REG_CHANNEL_SHIFT, 32'((0 << 10) | (5 << 5) | 11));
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 255, 128, 1, 255));
    send_pixel(make_pixel(REQ_SOURCE, 8, 40, 90, 200, 30, 77));

    // shifts of 31: everything past bit 31 is lost
    settle_unit();
    write_reg(REG_BYTES_PER_PIXEL, 32'd4);
    write_reg(REG_MSB_FIRST, 32'd0);
    write_reg(REG_CHANNEL_MAX, 32'hFFFFFF);
    write_reg(REG_CHANNEL_SHIFT, 32'h7FFF);
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 255, 255, 255, 255));

    // zero maxima give an all-zero word
    settle_unit();
    write_reg(REG_CHANNEL_MAX, 32'h000000);
    write_reg(REG_CHANNEL_SHIFT, 32'd0);
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 255, 255, 255, 255));

    // solid background, with and without alpha in use
    settle_unit();
    write_reg(REG_CHANNEL_MAX, 32'hFFFFFF);
    write_reg(REG_CHANNEL_SHIFT, 32'd272);
    write_reg(REG_SOLID_BACKGROUND, 32'd1);
    write_reg(REG_SOLID_COLOR, 32'h563412);
    write_reg(REG_SOURCE_HAS_ALPHA, 32'd0);
    send_pixel(make_pixel(REQ_BACKGROUND, 100, 100, 0, 0, 0, 0));
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 250, 5, 60, 64));
    settle_unit();
    write_reg(REG_SOURCE_HAS_ALPHA, 32'd1);
    write_reg(REG_SOLID_COLOR, 32'hFFFFFF);
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 250, 5, 60, 64));
    send_pixel(make_pixel(REQ_SOURCE, 0, 0, 0, 0, 0, 0));
  endtask

  // every register written with random data, read back masked to its width
  task automatic test_register_readback();
    logic [2:0]  regs[7];
    logic [31:0] got;
    regs = '{REG_CHANNEL_MAX, REG_CHANNEL_SHIFT, REG_BYTES_PER_PIXEL, REG_MSB_FIRST,
             REG_SOLID_BACKGROUND, REG_SOLID_COLOR, REG_SOURCE_HAS_ALPHA};
    settle_unit();
    foreach (regs[i]) write_reg(regs[i], $urandom);
    foreach (regs[i]) begin
      apb_access(regs[i], 1'b0, 32'd0, got);
      if (got !== cfg_value(regs[i]))
        report_failure($sformatf("reg %0d readback exp %h got %h",
                                 regs[i], cfg_value(regs[i]), got));
    end
  endtask

  // new random register setting (extremes weighted in), then random pixels
  task automatic test_random_traffic();
    logic [31:0] shift_val;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_unit();
      case ($urandom_range(0, 3))
        0:       write_reg(REG_CHANNEL_MAX, 32'h000000);
        1:       write_reg(REG_CHANNEL_MAX, 32'hFFFFFF);
        default: write_reg(REG_CHANNEL_MAX, $urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       shift_val = 32'd0;
        1:       shift_val = 32'h7FFF;
        2:       shift_val = 32'(CHANNEL_SHIFT_RST);
        3:       shift_val = $urandom;
        default: shift_val = 32'(($urandom_range(0, 24) << 10) |
                                 ($urandom_range(0, 24) << 5) | $urandom_range(0, 24));
      endcase
      write_reg(REG_CHANNEL_SHIFT, shift_val);
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_BYTES_PER_PIXEL, 32'($urandom_range(0, 7)));
      else
        write_reg(REG_BYTES_PER_PIXEL, 32'($urandom_range(2, 4)));
      write_reg(REG_MSB_FIRST, 32'($urandom_range(0, 1)));
      write_reg(REG_SOLID_BACKGROUND, 32'($urandom_range(0, 1)));
      write_reg(REG_SOLID_COLOR, $urandom);
      write_reg(REG_SOURCE_HAS_ALPHA, 32'($urandom_range(0, 3) != 0));

      calm = (ph == CALM_PHASE);
      repeat (PHASE_ITEMS) send_pixel(random_pixel());
      calm = 1'b0;
    end
  endtask

  // receiver holds off long enough that the pipe fills and stalls the input
  task automatic test_output_backpressure();
    settle_unit();
    write_reg(REG_CHANNEL_MAX, 32'hFFFFFF);
    write_reg(REG_CHANNEL_SHIFT, 32'(CHANNEL_SHIFT_RST));
    write_reg(REG_BYTES_PER_PIXEL, 32'd4);
    write_reg(REG_MSB_FIRST, 32'd1);
    calm = 1'b1;
    @(posedge clk);
    hold_request = 1'b1;
    repeat (40) send_pixel(random_pixel());
    calm = 1'b0;
    repeat (40) send_pixel(random_pixel());
  endtask

  initial begin
    failures     = 0;
    cycles       = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    req_type     = REQ_BACKGROUND;
    pixel_x      = '0;
    pixel_y      = '0;
    src_red      = '0;
    src_green    = '0;
    src_blue     = '0;
    src_alpha    = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cfg.chan_max    = CHANNEL_MAX_RST;
    cfg.chan_shift  = CHANNEL_SHIFT_RST;
    cfg.bpp         = BPP_RST;
    cfg.msb_first   = 1'b0;
    cfg.solid_bg    = 1'b0;
    cfg.solid_color = '0;
    cfg.alpha_en    = 1'b1;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_reset_state();
    test_register_settings();
    test_register_readback();
    test_random_traffic();
    test_output_backpressure();

    settle_unit();
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pacp_pkg.sv
rtl/core/pixel_alpha_composite_pack_unit.sv
rtl/core/pacp_checker.sv
tb/sv/tb_top.sv
